// File: sv/chj_pkg.sv
`timescale 1ns / 1ps
// chj_pkg: shared types and constants of the chained hash join table unit
// request and result transaction structs, request and status codes
// depends on nothing
package chj_pkg;

    localparam int KEY_WIDTH           = 32;
    localparam int PAYLOAD_WIDTH       = 32;
    localparam int ENTRIES_DEF         = 64;
    localparam int MAX_BUCKET_BITS_DEF = 6;
    localparam int CFG_WIDTH           = 3;
    localparam int REQ_WIDTH           = 2;
    localparam int STATUS_WIDTH        = 3;

    localparam logic [CFG_WIDTH-1:0] BUCKET_BITS_RST = 3'd6;

    localparam logic [REQ_WIDTH-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_PROBE  = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_MATCH    = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_NO_MATCH = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [REQ_WIDTH-1:0]     req_type;
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } chj_req_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]  status;
        logic [KEY_WIDTH-1:0]     match_key;
        logic [PAYLOAD_WIDTH-1:0] build_payload;
        logic [PAYLOAD_WIDTH-1:0] probe_payload;
        logic                     last;
    } chj_rsp_t;

endpackage

// File: sv/chained_hash_join_table_unit.sv
`timescale 1ns / 1ps
// chained_hash_join_table_unit: build and probe side of a chained hash join
// bucket head memory plus entry memories, walked by a small sequencer
// depends on chj_pkg
//
// Usage: requests come in on s_valid/s_ready/s_data (insert, probe, clear),
// results leave on m_valid/m_ready/m_data, one or more per request, the
// final one flagged by last. cfg_we/cfg_wdata set the bucket bit count; the
// user must write them only while the unit is idle; nothing in the unit enforces this.
// The unit works on one request at a time; s_ready is high while it idles.
// Insert, table full and clear: the result is registered once the output
// register is free, and the unit then returns to idle to take the next request.
// Probe: the bucket head is read on accept, then each chain entry visited
// costs one entry memory read; matches are emitted during the walk and the
// final result from the end state, after which the unit returns to idle.
// Results sit in an output register, so processing continues while a result
// waits; when a second one is due and the receiver stalls, the walk holds.
// Unknown request codes are accepted and dropped without a result.
// Reset empties all buckets at once (per-bucket valid flags), zeroes the
// entry count and sets the bucket bit count to six; no clearing pass.
module chained_hash_join_table_unit #(
    parameter int ENTRIES         = chj_pkg::ENTRIES_DEF,
    parameter int MAX_BUCKET_BITS = chj_pkg::MAX_BUCKET_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [chj_pkg::CFG_WIDTH-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  chj_pkg::chj_req_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output chj_pkg::chj_rsp_t              m_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int NB = 1 << MAX_BUCKET_BITS;
    localparam int BW = MAX_BUCKET_BITS;

    localparam logic [LW-1:0] EMPTY_LINK = {LW{1'b1}};
    localparam logic [LW-1:0] LINK_LIMIT = LW'(ENTRIES);
    localparam logic [CW-1:0] COUNT_FULL = CW'(ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_CLR   = 3'd2;
    localparam logic [2:0] S_PHEAD = 3'd3;
    localparam logic [2:0] S_PCMP  = 3'd4;
    localparam logic [2:0] S_PEND  = 3'd5;

    // memories
    logic [LW-1:0]                     head_mem [NB];
    logic [chj_pkg::KEY_WIDTH-1:0]     key_mem  [ENTRIES];
    logic [chj_pkg::PAYLOAD_WIDTH-1:0] pay_mem  [ENTRIES];
    logic [LW-1:0]                     next_mem [ENTRIES];

    logic [LW-1:0]                     head_rd_reg;
    logic [chj_pkg::KEY_WIDTH-1:0]     ent_key_rd_reg;
    logic [chj_pkg::PAYLOAD_WIDTH-1:0] ent_pay_rd_reg;
    logic [LW-1:0]                     ent_next_rd_reg;

    // control state
    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [NB-1:0]                head_vld_reg, head_vld_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic                         m_valid_reg, m_valid_next;
    logic [chj_pkg::CFG_WIDTH-1:0] bb_reg;

    // payload state
    chj_pkg::chj_req_t                 req_reg;
    logic [BW-1:0]                     bucket_reg;
    logic [chj_pkg::PAYLOAD_WIDTH-1:0] pend_pay_reg, pend_pay_next;
    chj_pkg::chj_rsp_t                 m_data_reg, m_data_next;

    logic                         s_acc;
    logic                         out_free;
    logic [chj_pkg::CFG_WIDTH-1:0] bb_eff;
    logic [BW-1:0]                s_bucket;
    logic [LW-1:0]                head_link;
    logic                         hit;
    logic                         next_end;
    logic                         emit;
    chj_pkg::chj_rsp_t            emit_data;
    logic                         ins_we;
    logic                         ent_re;
    logic [IW-1:0]                ent_raddr;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // bucket of the incoming key: low bits, count clamped to the maximum
    always_comb begin
        bb_eff = (bb_reg > chj_pkg::CFG_WIDTH'(MAX_BUCKET_BITS)) ?
                 chj_pkg::CFG_WIDTH'(MAX_BUCKET_BITS) : bb_reg;
        for (int i = 0; i < BW; i++) begin
            s_bucket[i] = s_data.key[i] & (chj_pkg::CFG_WIDTH'(i) < bb_eff);
        end
    end

    // an empty bucket reads as the end-of-chain marker
    assign head_link = head_vld_reg[bucket_reg] ? head_rd_reg : EMPTY_LINK;
    assign hit       = (ent_key_rd_reg == req_reg.key);
    assign next_end  = (ent_next_rd_reg >= LINK_LIMIT);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_vld_next = head_vld_reg;
        pend_vld_next = pend_vld_reg;
        pend_pay_next = pend_pay_reg;
        emit          = 1'b0;
        emit_data     = '0;
        ins_we        = 1'b0;
        ent_re        = 1'b0;
        ent_raddr     = head_link[IW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_data.req_type)
                        chj_pkg::REQ_INSERT: state_next = S_INS;
                        chj_pkg::REQ_PROBE:  state_next = S_PHEAD;
                        chj_pkg::REQ_CLEAR:  state_next = S_CLR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit                = 1'b1;
                    emit_data.match_key = req_reg.key;
                    emit_data.last      = 1'b1;
                    if (count_reg == COUNT_FULL) begin
                        emit_data.status = chj_pkg::ST_FULL;
                    end else begin
                        emit_data.status           = chj_pkg::ST_INSERTED;
                        ins_we                     = 1'b1;
                        count_next                 = count_reg + 1'b1;
                        head_vld_next[bucket_reg]  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CLR: begin
                if (out_free) begin
                    emit             = 1'b1;
                    emit_data.status = chj_pkg::ST_CLEARED;
                    emit_data.last   = 1'b1;
                    head_vld_next    = '0;
                    count_next       = '0;
                    state_next       = S_IDLE;
                end
            end
            S_PHEAD: begin
                if (head_link >= LINK_LIMIT) begin
                    state_next = S_PEND;
                end else begin
                    ent_re     = 1'b1;
                    ent_raddr  = head_link[IW-1:0];
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                // a match is held back one step so the final one can carry last
                if (!(hit && pend_vld_reg && !out_free)) begin
                    if (hit) begin
                        if (pend_vld_reg) begin
                            emit                    = 1'b1;
                            emit_data.status        = chj_pkg::ST_MATCH;
                            emit_data.match_key     = req_reg.key;
                            emit_data.build_payload = pend_pay_reg;
                            emit_data.probe_payload = req_reg.payload;
                            emit_data.last          = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_pay_next = ent_pay_rd_reg;
                    end
                    if (next_end) begin
                        state_next = S_PEND;
                    end else begin
                        ent_re    = 1'b1;
                        ent_raddr = ent_next_rd_reg[IW-1:0];
                    end
                end
            end
            S_PEND: begin
                if (out_free) begin
                    emit                    = 1'b1;
                    emit_data.match_key     = req_reg.key;
                    emit_data.probe_payload = req_reg.payload;
                    emit_data.last          = 1'b1;
                    if (pend_vld_reg) begin
                        emit_data.status        = chj_pkg::ST_MATCH;
                        emit_data.build_payload = pend_pay_reg;
                    end else begin
                        emit_data.status = chj_pkg::ST_NO_MATCH;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = emit ? emit_data : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_vld_reg <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            bb_reg       <= chj_pkg::BUCKET_BITS_RST;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_vld_reg <= head_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                bb_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_reg    <= s_data;
            bucket_reg <= s_bucket;
        end
        pend_pay_reg <= pend_pay_next;
        m_data_reg   <= m_data_next;
    end

    // bucket head memory: read on accept, written when an insert commits
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            head_rd_reg <= head_mem[s_bucket];
        end
        if (ins_we) begin
            head_mem[bucket_reg] <= LW'(count_reg);
        end
    end

    // entry memories: new row goes to the slot at the fill count
    always_ff @(posedge aclk) begin
        if (ent_re) begin
            ent_key_rd_reg  <= key_mem[ent_raddr];
            ent_pay_rd_reg  <= pay_mem[ent_raddr];
            ent_next_rd_reg <= next_mem[ent_raddr];
        end
        if (ins_we) begin
            key_mem[count_reg[IW-1:0]]  <= req_reg.key;
            pay_mem[count_reg[IW-1:0]]  <= req_reg.payload;
            next_mem[count_reg[IW-1:0]] <= head_link;
        end
    end

endmodule

// File: test/chained_hash_join_table_unit_tb.sv
`timescale 1ns / 1ps
// chained_hash_join_table_unit_tb: self-checking bench for the chained hash join table unit
// directed rows, then random insert/probe/clear episodes under every bucket width setting
// depends on chj_pkg and chained_hash_join_table_unit
module chained_hash_join_table_unit_tb;

    localparam int TABLE_SLOTS  = chj_pkg::ENTRIES_DEF;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam int HEAD_BITS    = chj_pkg::MAX_BUCKET_BITS_DEF;
    localparam int HEAD_SLOTS   = 1 << HEAD_BITS;
    localparam logic [6:0] NO_LINK = 7'h7F;
    localparam logic [chj_pkg::REQ_WIDTH-1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_CAP    = 60;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 25;
    localparam int DIR_ROWS     = 17;

    typedef struct packed {
        chj_pkg::chj_req_t req;
        logic              pinned;
        chj_pkg::chj_rsp_t rsp;
    } directed_row_t;

    localparam chj_pkg::chj_rsp_t NO_RSP = '0;

    // pinned rows carry the result typed in; the others go through the table mirror
    localparam directed_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{'{chj_pkg::REQ_PROBE, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{chj_pkg::ST_NO_MATCH, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1}},
        '{'{chj_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'h0000_0000, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_INSERT, 32'h0000_0000, 32'h1234_5678}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'h0000_0000, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_PROBE, 32'h0000_0000, 32'hA5A5_A5A5}, 1'b0, NO_RSP},
        '{'{chj_pkg::REQ_PROBE, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
          '{chj_pkg::ST_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_PROBE, 32'h0000_0040, 32'h5A5A_5A5A}, 1'b1,
          '{chj_pkg::ST_NO_MATCH, 32'h0000_0040, 32'h0, 32'h5A5A_5A5A, 1'b1}},
        '{'{REQ_UNUSED, 32'hDEAD_BEEF, 32'h0BAD_F00D}, 1'b0, NO_RSP},
        '{'{chj_pkg::REQ_INSERT, 32'h8000_0040, 32'h5555_AAAA}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'h8000_0040, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_PROBE, 32'h8000_0040, 32'hC3C3_C3C3}, 1'b0, NO_RSP},
        '{'{chj_pkg::REQ_CLEAR, 32'h1357_9BDF, 32'h2468_ACE0}, 1'b1,
          '{chj_pkg::ST_CLEARED, 32'h0, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_PROBE, 32'h0000_0000, 32'h0000_0001}, 1'b1,
          '{chj_pkg::ST_NO_MATCH, 32'h0000_0000, 32'h0, 32'h0000_0001, 1'b1}},
        '{'{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_RSP},
        '{'{chj_pkg::REQ_INSERT, 32'h0000_003F, 32'h0000_0001}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'h0000_003F, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0002}, 1'b1,
          '{chj_pkg::ST_INSERTED, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1}},
        '{'{chj_pkg::REQ_PROBE, 32'h0000_003F, 32'hFFFF_0000}, 1'b0, NO_RSP},
        '{'{chj_pkg::REQ_PROBE, 32'h7FFF_FFFF, 32'h0000_FFFF}, 1'b0, NO_RSP}
    };

    localparam logic [chj_pkg::CFG_WIDTH-1:0] PHASE_BITS [PHASES] = '{
        3'd0, 3'd7, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4
    };

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [chj_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    chj_pkg::chj_req_t             s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    chj_pkg::chj_rsp_t             m_data;

    chained_hash_join_table_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // mirror of the table contents
    logic [6:0]                        mirror_head    [HEAD_SLOTS];
    logic [6:0]                        mirror_next    [TABLE_SLOTS];
    logic [chj_pkg::KEY_WIDTH-1:0]     mirror_key     [TABLE_SLOTS];
    logic [chj_pkg::PAYLOAD_WIDTH-1:0] mirror_payload [TABLE_SLOTS];
    int unsigned                       mirror_fill;
    logic [chj_pkg::CFG_WIDTH-1:0]     mirror_bits;

    chj_pkg::chj_rsp_t step_results [$];
    chj_pkg::chj_rsp_t due_results  [$];
    logic [31:0]       key_pool     [$];

    logic              row_pinned = 1'b0;
    chj_pkg::chj_rsp_t row_rsp    = '0;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                error_count  = 0;
    int                quiet_cycles = 0;
    int                rsp_seen     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [HEAD_BITS-1:0] bucket_index(
        input logic [chj_pkg::KEY_WIDTH-1:0] key);
        int unsigned width;
        logic [31:0] mask;
        width = (mirror_bits > chj_pkg::MAX_BUCKET_BITS_DEF) ?
                chj_pkg::MAX_BUCKET_BITS_DEF : mirror_bits;
        mask  = (32'h1 << width) - 32'h1;
        return key[HEAD_BITS-1:0] & mask[HEAD_BITS-1:0];
    endfunction

    // applies one request to the mirror, leaves its results in step_results
    function automatic void join_table_step(input chj_pkg::chj_req_t r);
        chj_pkg::chj_rsp_t      rsp;
        logic [SLOT_BITS-1:0]   slot;
        logic [HEAD_BITS-1:0]   hd;
        logic [6:0]             cur;
        step_results.delete();
        rsp           = '0;
        rsp.match_key = r.key;
        rsp.last      = 1'b1;
        case (r.req_type)
            chj_pkg::REQ_INSERT: begin
                if (mirror_fill >= TABLE_SLOTS) begin
                    rsp.status = chj_pkg::ST_FULL;
                end else begin
                    slot                 = mirror_fill[SLOT_BITS-1:0];
                    hd                   = bucket_index(r.key);
                    mirror_key[slot]     = r.key;
                    mirror_payload[slot] = r.payload;
                    mirror_next[slot]    = mirror_head[hd];
                    mirror_head[hd]      = 7'(slot);
                    mirror_fill++;
                    rsp.status = chj_pkg::ST_INSERTED;
                end
                step_results.insert(step_results.size(), rsp);
            end
            chj_pkg::REQ_PROBE: begin
                rsp.status        = chj_pkg::ST_MATCH;
                rsp.probe_payload = r.payload;
                rsp.last          = 1'b0;
                cur = mirror_head[bucket_index(r.key)];
                // newest to oldest, a link past the table ends the chain
                for (int steps = 0; steps < TABLE_SLOTS && cur < TABLE_SLOTS; steps++) begin
                    if (mirror_key[cur[SLOT_BITS-1:0]] == r.key) begin
                        rsp.build_payload = mirror_payload[cur[SLOT_BITS-1:0]];
                        step_results.insert(step_results.size(), rsp);
                    end
                    cur = mirror_next[cur[SLOT_BITS-1:0]];
                end
                if (step_results.size() == 0) begin
                    rsp.status        = chj_pkg::ST_NO_MATCH;
                    rsp.build_payload = '0;
                    rsp.last          = 1'b1;
                    step_results.insert(0, rsp);
                end else begin
                    step_results[step_results.size() - 1].last = 1'b1;
                end
            end
            chj_pkg::REQ_CLEAR: begin
                foreach (mirror_head[i]) mirror_head[i] = NO_LINK;
                mirror_fill   = 0;
                rsp.status    = chj_pkg::ST_CLEARED;
                rsp.match_key = '0;
                step_results.insert(step_results.size(), rsp);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t: result %0d %s: got %h, want %h", $realtime, rsp_seen, what, got,
                     want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        chj_pkg::chj_rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                rsp_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch("transaction with nothing due, status",
                                    32'(m_data.status), '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.match_key !== want.match_key)
                        report_mismatch("match_key", m_data.match_key, want.match_key);
                    if (m_data.build_payload !== want.build_payload)
                        report_mismatch("build_payload", m_data.build_payload,
                                        want.build_payload);
                    if (m_data.probe_payload !== want.probe_payload)
                        report_mismatch("probe_payload", m_data.probe_payload,
                                        want.probe_payload);
                    if (m_data.last !== want.last)
                        report_mismatch("last", 32'(m_data.last), 32'(want.last));
                end
            end
            if (s_valid && s_ready) begin
                join_table_step(s_data);
                if (row_pinned)
                    due_results.insert(due_results.size(), row_rsp);
                else
                    foreach (step_results[i])
                        due_results.insert(due_results.size(), step_results[i]);
            end
            if (cfg_we)
                mirror_bits = cfg_wdata;
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[chained_hash_join_table_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic offer_request(input logic [chj_pkg::REQ_WIDTH-1:0] kind,
                                 input logic [chj_pkg::KEY_WIDTH-1:0] key,
                                 input logic [chj_pkg::PAYLOAD_WIDTH-1:0] payload,
                                 input logic pin, input chj_pkg::chj_rsp_t pinned_rsp);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        row_pinned = pin;
        row_rsp    = pinned_rsp;
        s_valid   <= 1'b1;
        s_data    <= '{kind, key, payload};
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every result is back, then let the unit settle
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_bucket_bits(input logic [chj_pkg::CFG_WIDTH-1:0] bits);
        wait_results_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic make_key_pool(input int n);
        logic [31:0] k;
        key_pool.delete();
        repeat (n) begin
            k = $urandom;
            // crowd some keys into the low buckets
            if ($urandom_range(1)) k[5:0] = 6'($urandom_range(3));
            key_pool.insert(key_pool.size(), k);
        end
    endtask

    function automatic logic [31:0] pick_probe_key();
        int unsigned roll;
        logic [31:0] k;
        roll = $urandom_range(99);
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        if (roll < 65)
            return k;
        // same bucket under any width, different key
        if (roll < 85)
            return k ^ (32'h1 << $urandom_range(31, 6));
        return $urandom;
    endfunction

    // one long chain set: fills past capacity, then probes with up to a full table of hits
    task automatic fill_table(input int n_keys);
        offer_request(chj_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, NO_RSP);
        make_key_pool(n_keys);
        repeat (TABLE_SLOTS + 2)
            offer_request(chj_pkg::REQ_INSERT, key_pool[$urandom_range(n_keys - 1)],
                          $urandom, 1'b0, NO_RSP);
        repeat (8)
            offer_request(chj_pkg::REQ_PROBE, pick_probe_key(), $urandom, 1'b0, NO_RSP);
    endtask

    task automatic run_episodes(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 20) wait_results_drained();
            if ($urandom_range(99) < 70) begin
                offer_request(chj_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, NO_RSP);
                sent++;
            end
            make_key_pool($urandom_range(1, 6));
            repeat ($urandom_range(1, 12)) begin
                offer_request(chj_pkg::REQ_INSERT,
                              key_pool[$urandom_range(key_pool.size() - 1)],
                              $urandom, 1'b0, NO_RSP);
                sent++;
            end
            repeat ($urandom_range(1, 8)) begin
                offer_request(chj_pkg::REQ_PROBE, pick_probe_key(), $urandom, 1'b0,
                              NO_RSP);
                sent++;
            end
            if ($urandom_range(99) < 30)
                offer_request(REQ_UNUSED, $urandom, $urandom, 1'b0, NO_RSP);
        end
    endtask

    initial begin
        foreach (mirror_head[i]) mirror_head[i] = NO_LINK;
        mirror_fill   = 0;
        mirror_bits   = chj_pkg::BUCKET_BITS_RST;
        send_idle_pct = 35;
        recv_idle_pct = 77;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_request(DIRECTED_ROWS[i].req.req_type, DIRECTED_ROWS[i].req.key,
                          DIRECTED_ROWS[i].req.payload, DIRECTED_ROWS[i].pinned,
                          DIRECTED_ROWS[i].rsp);

        // width changes keep the table contents unless an episode clears it
        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 77;
                recv_idle_pct = 35;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_bucket_bits(PHASE_BITS[p]);
            if (p == 1)
                fill_table(1);
            else if (p == 3)
                fill_table(3);
            run_episodes(PHASE_ITEMS);
        end

        wait_results_drained();
        if (error_count == 0)
            $display("[chained_hash_join_table_unit] OK");
        else
            $display("[chained_hash_join_table_unit] ERROR");
        $finish;
    end

endmodule

// File: chained_hash_join_table_unit.f
sv/chj_pkg.sv
sv/chained_hash_join_table_unit.sv
test/chained_hash_join_table_unit_tb.sv
